// ----- src/ctb_pkg.sv -----
`timescale 1ns / 1ps

package ctb_pkg;

    localparam int DEF_TIMER_COUNT        = 16;
    localparam int DEF_TICKS_PER_TENTH    = 100;
    localparam int DEF_TENTHS_PER_SECOND  = 10;
    localparam int DEF_SECONDS_PER_MINUTE = 60;

    localparam int OP_W   = 4;
    localparam int IDX_W  = 4;
    localparam int TIME_W = 32;
    localparam int UNIT_W = 2;
    localparam int MASK_W = 16;

    localparam int IN_IDX_LSB  = 0;
    localparam int IN_TIME_LSB = IN_IDX_LSB + IDX_W;
    localparam int IN_UNIT_LSB = IN_TIME_LSB + TIME_W;
    localparam int IN_HOLD_LSB = IN_UNIT_LSB + UNIT_W;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 48;

    localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
    localparam logic [OP_W-1:0] OP_START      = 4'd1;
    localparam logic [OP_W-1:0] OP_SET        = 4'd2;
    localparam logic [OP_W-1:0] OP_READ_SCALE = 4'd3;
    localparam logic [OP_W-1:0] OP_READ_RAW   = 4'd4;
    localparam logic [OP_W-1:0] OP_HOLD       = 4'd5;
    localparam logic [OP_W-1:0] OP_STOP       = 4'd6;
    localparam logic [OP_W-1:0] OP_READ_TICKS = 4'd7;
    localparam logic [OP_W-1:0] OP_COLLECT    = 4'd8;

    localparam logic [UNIT_W-1:0] UNIT_RAW    = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_TENTH  = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_SECOND = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_MINUTE = 2'd3;

    typedef struct packed {
        logic capture;
        logic tick_inc;
        logic sweep_start;
        logic sweep_step;
        logic rd_idx;
        logic mul;
        logic wr_entry;
        logic raw;
        logic div_start;
        logic apply;
        logic out_load;
    } ctb_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            sweep_last;
        logic            div_done;
        logic            out_free;
    } ctb_status_t;

endpackage

// ----- src/ctb_divider.sv -----
`timescale 1ns / 1ps

module ctb_divider
    import ctb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    input  logic [TIME_W-1:0] recip,
    output logic              done,
    output logic [TIME_W-1:0] quotient
);

    logic [TIME_W-1:0]   num_reg;
    logic [TIME_W-1:0]   dvs_reg;
    logic [TIME_W-1:0]   rcp_reg;
    logic [TIME_W-1:0]   est_reg;
    logic [TIME_W-1:0]   rem_reg;
    logic [TIME_W-1:0]   quo_reg;
    logic [2:0]          stage_reg;
    logic                done_reg;
    logic [2*TIME_W-1:0] product;
    logic [TIME_W-1:0]   back;

    // The estimate from the reciprocal is the exact quotient or one below it.
    assign product = (2*TIME_W)'(num_reg) * (2*TIME_W)'(rcp_reg);
    assign back    = est_reg * dvs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= stage_reg[2];
            if (start) begin
                stage_reg <= 3'b001;
            end else begin
                stage_reg <= {stage_reg[1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            dvs_reg <= divisor;
            rcp_reg <= recip;
        end
        if (stage_reg[0]) begin
            est_reg <= product[2*TIME_W-1:TIME_W];
        end
        if (stage_reg[1]) begin
            rem_reg <= num_reg - back;
        end
        if (stage_reg[2]) begin
            quo_reg <= (rem_reg >= dvs_reg) ? est_reg + TIME_W'(1) : est_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/ctb_ctrl.sv -----
`timescale 1ns / 1ps

module ctb_ctrl
    import ctb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  ctb_status_t status,
    output ctb_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_WRITE  = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_SWEEP  = 3'd5;
    localparam logic [2:0] ST_RESULT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.op)
                    OP_TICK: begin
                        cmd.tick_inc    = 1'b1;
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_SWEEP;
                    end
                    OP_START: begin
                        cmd.mul    = 1'b1;
                        state_next = ST_WRITE;
                    end
                    OP_SET, OP_READ_SCALE, OP_READ_RAW: begin
                        cmd.rd_idx = 1'b1;
                        state_next = ST_READ;
                    end
                    default: begin
                        cmd.apply  = 1'b1;
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_READ: begin
                case (status.op)
                    OP_SET: begin
                        cmd.mul    = 1'b1;
                        state_next = ST_WRITE;
                    end
                    OP_READ_SCALE: begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    default: begin
                        cmd.raw    = 1'b1;
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_WRITE: begin
                cmd.wr_entry = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/ctb_datapath.sv -----
`timescale 1ns / 1ps

module ctb_datapath
    import ctb_pkg::*;
#(
    parameter int TIMER_COUNT        = DEF_TIMER_COUNT,
    parameter int TICKS_PER_TENTH    = DEF_TICKS_PER_TENTH,
    parameter int TENTHS_PER_SECOND  = DEF_TENTHS_PER_SECOND,
    parameter int SECONDS_PER_MINUTE = DEF_SECONDS_PER_MINUTE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [OP_W-1:0]       in_op,
    input  ctb_cmd_t              cmd,
    output ctb_status_t           status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int IW = (AW > IDX_W) ? AW : IDX_W;
    localparam int MW = (TIMER_COUNT < MASK_W) ? TIMER_COUNT : MASK_W;
    localparam int EW = UNIT_W + TIME_W;

    localparam logic [TIME_W-1:0] MUL_TENTH  = TIME_W'(TICKS_PER_TENTH);
    localparam logic [TIME_W-1:0] MUL_SECOND = TIME_W'(TICKS_PER_TENTH * TENTHS_PER_SECOND);
    localparam logic [TIME_W-1:0] MUL_MINUTE =
        TIME_W'(TICKS_PER_TENTH * TENTHS_PER_SECOND * SECONDS_PER_MINUTE);

    localparam logic [TIME_W-1:0] RCP_RAW    = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] RCP_TENTH  = {TIME_W{1'b1}} / MUL_TENTH;
    localparam logic [TIME_W-1:0] RCP_SECOND = {TIME_W{1'b1}} / MUL_SECOND;
    localparam logic [TIME_W-1:0] RCP_MINUTE = {TIME_W{1'b1}} / MUL_MINUTE;

    function automatic logic [TIME_W-1:0] unit_factor(input logic [UNIT_W-1:0] unit);
        logic [TIME_W-1:0] f;
        case (unit)
            UNIT_TENTH:  f = MUL_TENTH;
            UNIT_SECOND: f = MUL_SECOND;
            UNIT_MINUTE: f = MUL_MINUTE;
            default:     f = TIME_W'(1);
        endcase
        return f;
    endfunction

    function automatic logic [TIME_W-1:0] unit_recip(input logic [UNIT_W-1:0] unit);
        logic [TIME_W-1:0] r;
        case (unit)
            UNIT_TENTH:  r = RCP_TENTH;
            UNIT_SECOND: r = RCP_SECOND;
            UNIT_MINUTE: r = RCP_MINUTE;
            default:     r = RCP_RAW;
        endcase
        return r;
    endfunction

    logic [OP_W-1:0]        op_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [TIME_W-1:0]      tval_reg;
    logic [UNIT_W-1:0]      base_reg;
    logic                   hold_in_reg;
    logic [TIME_W-1:0]      tick_count_reg;
    logic [TIME_W-1:0]      mult_reg;
    logic [TIME_W-1:0]      res_data_reg;
    logic [MASK_W-1:0]      res_mask_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [AW-1:0]          sw_reg;

    logic [EW-1:0]          mem [TIMER_COUNT];
    logic [EW-1:0]          mem_rd_reg;
    logic                   rd_valid_reg;
    logic [TIMER_COUNT-1:0] entry_valid_reg;
    logic [TIMER_COUNT-1:0] hold_reg;
    logic [TIMER_COUNT-1:0] expired_reg;

    logic [IW-1:0]          idx_wide;
    logic [AW-1:0]          idx_addr;
    logic                   idx_ok;
    logic [TIME_W-1:0]      rd_count;
    logic [UNIT_W-1:0]      rd_unit;
    logic [UNIT_W-1:0]      unit_sel;
    logic                   dec_en;
    logic [TIME_W-1:0]      dec_count;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic                   we;
    logic [AW-1:0]          wr_addr;
    logic [EW-1:0]          wr_data;
    logic [MASK_W-1:0]      collect_mask;
    logic                   div_done;
    logic [TIME_W-1:0]      div_quotient;

    assign idx_wide     = IW'(idx_reg);
    assign idx_addr     = idx_wide[AW-1:0];
    assign idx_ok       = {{(32 - IDX_W){1'b0}}, idx_reg} < 32'(TIMER_COUNT);
    assign rd_count     = rd_valid_reg ? mem_rd_reg[TIME_W-1:0] : '0;
    assign rd_unit      = rd_valid_reg ? mem_rd_reg[EW-1:TIME_W] : UNIT_RAW;
    assign unit_sel     = (op_reg == OP_START) ? base_reg : rd_unit;
    assign dec_en       = (rd_count != '0) && !hold_reg[sw_reg];
    assign dec_count    = rd_count - TIME_W'(1);
    assign collect_mask = MASK_W'(expired_reg[MW-1:0]);

    always_comb begin
        rd_en = cmd.rd_idx | cmd.sweep_start | cmd.sweep_step;
        if (cmd.sweep_start) begin
            rd_addr = '0;
        end else if (cmd.sweep_step) begin
            rd_addr = sw_reg + AW'(1);
        end else begin
            rd_addr = idx_addr;
        end
        we      = 1'b0;
        wr_addr = idx_addr;
        wr_data = {unit_sel, mult_reg};
        if (cmd.sweep_step) begin
            we      = dec_en;
            wr_addr = sw_reg;
            wr_data = {rd_unit, dec_count};
        end else if (cmd.wr_entry) begin
            we = idx_ok;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            hold_reg        <= '0;
            expired_reg     <= '0;
            tick_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (rd_en) begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
            end
            if (we) begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.tick_inc) begin
                tick_count_reg <= tick_count_reg + TIME_W'(1);
            end
            if (cmd.sweep_step && dec_en && dec_count == '0) begin
                expired_reg[sw_reg] <= 1'b1;
            end
            if (cmd.wr_entry && idx_ok && op_reg == OP_START) begin
                expired_reg[idx_addr] <= (mult_reg == '0);
            end
            if (cmd.apply) begin
                case (op_reg)
                    OP_HOLD: begin
                        if (idx_ok) begin
                            hold_reg[idx_addr] <= hold_in_reg;
                        end
                    end
                    OP_STOP: begin
                        if (idx_ok) begin
                            entry_valid_reg[idx_addr] <= 1'b0;
                            hold_reg[idx_addr]        <= 1'b0;
                            expired_reg[idx_addr]     <= 1'b0;
                        end
                    end
                    OP_COLLECT: begin
                        expired_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= in_op;
            idx_reg      <= in_data[IN_IDX_LSB +: IDX_W];
            tval_reg     <= in_data[IN_TIME_LSB +: TIME_W];
            base_reg     <= in_data[IN_UNIT_LSB +: UNIT_W];
            hold_in_reg  <= in_data[IN_HOLD_LSB];
            res_data_reg <= '0;
            res_mask_reg <= '0;
        end
        if (cmd.sweep_start) begin
            sw_reg <= '0;
        end else if (cmd.sweep_step) begin
            sw_reg <= sw_reg + AW'(1);
        end
        if (cmd.mul) begin
            mult_reg <= tval_reg * unit_factor(unit_sel);
        end
        if (cmd.raw) begin
            res_data_reg <= idx_ok ? rd_count : '0;
        end
        if (div_done) begin
            res_data_reg <= idx_ok ? div_quotient : '0;
        end
        if (cmd.apply) begin
            if (op_reg == OP_READ_TICKS) begin
                res_data_reg <= tick_count_reg;
            end
            if (op_reg == OP_COLLECT) begin
                res_mask_reg <= collect_mask;
            end
        end
        if (cmd.out_load) begin
            out_data_reg <= {res_mask_reg, res_data_reg};
        end
    end

    ctb_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (rd_count),
        .divisor  (unit_factor(rd_unit)),
        .recip    (unit_recip(rd_unit)),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign status.op         = op_reg;
    assign status.sweep_last = (sw_reg == AW'(TIMER_COUNT - 1));
    assign status.div_done   = div_done;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_data          = out_data_reg;

endmodule

// ----- src/countdown_timer_bank.sv -----
// Steps to a result: hold, stop, tick readout and collect pass decode and result; start adds a
// write, raw read a read, set both, a tick a sweep (one timer per cycle through the count
// memory) and a scaled read a read and a divide (reciprocal multiply and one correction step).
// One item is in work at a time; the next is accepted the cycle after a result is registered.
// Synchronous active-low reset clears the flags, tick count and output valid, not the memory.
`timescale 1ns / 1ps

module countdown_timer_bank
    import ctb_pkg::*;
#(
    parameter int TIMER_COUNT        = DEF_TIMER_COUNT,
    parameter int TICKS_PER_TENTH    = DEF_TICKS_PER_TENTH,
    parameter int TENTHS_PER_SECOND  = DEF_TENTHS_PER_SECOND,
    parameter int SECONDS_PER_MINUTE = DEF_SECONDS_PER_MINUTE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // timer_index, time_value, time_base, hold, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_data, event_mask
    output logic [OUT_DATA_W-1:0] m_tdata
);

    ctb_cmd_t    cmd;
    ctb_status_t status;

    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ctb_datapath #(
        .TIMER_COUNT        (TIMER_COUNT),
        .TICKS_PER_TENTH    (TICKS_PER_TENTH),
        .TENTHS_PER_SECOND  (TENTHS_PER_SECOND),
        .SECONDS_PER_MINUTE (SECONDS_PER_MINUTE)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_data   (s_tdata),
        .in_op     (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ----- src/ctb_checker.sv -----
`timescale 1ns / 1ps

module ctb_checker
    import ctb_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_one_item_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while one is in work");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    a_mask_or_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:0] == '0 || m_tdata[47:32] == '0))
        else $error("result carries both read data and an event mask");

endmodule

bind countdown_timer_bank ctb_checker u_checker (.*);
